### design/dsst_pkg.sv
`timescale 1ns / 1ps
package dsst_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned DECAY_ENTRIES_DEF = 64;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  localparam logic [16:0] SCORE_ONE = 17'd65536;
  localparam logic [47:0] HALF_LIFE_RST = 48'd1000000000;
  localparam logic [16:0] INCREMENT_RST = 17'd6554;

  typedef enum logic [1:0] {
    ACT_ALERT = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic {
    CFG_HALF_LIFE = 1'b0,
    CFG_INCREMENT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIVIDE,
    ST_MULTIPLY,
    ST_ROUND,
    ST_RESULT,
    ST_DONE
  } state_t;

  // divide by a small series index; only used while elaborating the factor table
  function automatic logic [63:0] div_small(input logic [63:0] x, input int unsigned n);
    logic [63:0] y;
    unique case (n)
      1: y = x;          2: y = x / 2;      3: y = x / 3;      4: y = x / 4;
      5: y = x / 5;      6: y = x / 6;      7: y = x / 7;      8: y = x / 8;
      9: y = x / 9;      10: y = x / 10;    11: y = x / 11;    12: y = x / 12;
      13: y = x / 13;    14: y = x / 14;    15: y = x / 15;    16: y = x / 16;
      17: y = x / 17;    18: y = x / 18;    19: y = x / 19;    20: y = x / 20;
      21: y = x / 21;    22: y = x / 22;    23: y = x / 23;    24: y = x / 24;
      default: y = x;
    endcase
    return y;
  endfunction

  // exp(-t) for t in Q32, returned in Q16 with rounding
  function automatic logic [16:0] frac_factor(input logic [63:0] t);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] diff;
    term = 64'd1 << 32;
    pos = term;
    neg = 64'd0;
    for (int n = 1; n <= 24; n++) begin
      term = div_small((term * t) >> 32, n);
      if ((n % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    diff = (pos - neg) + 64'd32768;
    return 17'(diff >> 16);
  endfunction

endpackage

### design/decaying_symbol_score_table_top.sv
`timescale 1ns / 1ps
// Per-symbol score table with exponential decay. One item is handled at a time: a lookup walks
// the table by linear probing, each slot read from memory and then compared, and an
// alert or query on a stored nonzero, older score then runs a bit-serial divider of the
// elapsed time by the half-life, with log2(DECAY_TABLE_ENTRIES) fraction bits, followed by a
// multiply and a rounding step. TABLE_DEPTH and DECAY_TABLE_ENTRIES must be powers of two.
// Slot contents sit in one single-port-write, registered-read memory; valid bits are
// flip-flops cleared at once.
module decaying_symbol_score_table_top #(
  parameter int unsigned TABLE_DEPTH = dsst_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned DECAY_TABLE_ENTRIES = dsst_pkg::DECAY_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_symbol_id,
  input  logic [63:0] in_now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_score_value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned KW = $clog2(DECAY_TABLE_ENTRIES);
  localparam int unsigned DW = 64 + KW;
  localparam int unsigned DCW = $clog2(DW + 1);
  localparam int unsigned EW = 16 + 17 + 64;

  // configuration registers
  logic [47:0] half_life_r;
  logic [16:0] increment_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_life_r <= dsst_pkg::HALF_LIFE_RST;
      increment_r <= dsst_pkg::INCREMENT_RST;
    end else if (cfg_we) begin
      unique case (dsst_pkg::cfg_index_t'(cfg_index))
        dsst_pkg::CFG_HALF_LIFE: half_life_r <= cfg_wdata;
        dsst_pkg::CFG_INCREMENT: increment_r <= cfg_wdata[16:0];
      endcase
    end
  end

  logic [47:0] hl_eff;
  assign hl_eff = (half_life_r == 48'd0) ? 48'd1 : half_life_r;

  // fractional decay factors, built at elaboration
  logic [16:0] fac_tab [DECAY_TABLE_ENTRIES];
  for (genvar gi = 0; gi < DECAY_TABLE_ENTRIES; gi++) begin : g_fac
    localparam logic [63:0] TV = (64'(gi) * dsst_pkg::LN2_Q32) / 64'(DECAY_TABLE_ENTRIES);
    localparam logic [16:0] FV = dsst_pkg::frac_factor(TV);
    assign fac_tab[gi] = FV;
  end

  // control and working registers
  dsst_pkg::state_t state_r, state_nxt;
  dsst_pkg::action_t act_r, act_nxt;
  logic [15:0] sym_r, sym_nxt;
  logic [63:0] now_r, now_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW:0] cnt_r, cnt_nxt;
  logic claimed_r, claimed_nxt;
  logic [16:0] score_r, score_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [33:0] prod_r, prod_nxt;
  logic [16:0] dec_r, dec_nxt;
  logic [16:0] res_r, res_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [16:0] out_score_r, out_score_nxt;

  // memory port signals
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [15:0] rd_sym;
  logic [16:0] rd_score;
  logic [63:0] rd_stamp;

  assign {rd_sym, rd_score, rd_stamp} = ram_rdata;

  dsst_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  logic in_xfer;
  assign in_stall = (state_r != dsst_pkg::ST_IDLE);
  assign in_xfer = in_valid && !in_stall;

  // divider step
  logic [48:0] trial;
  logic trial_ge;
  assign trial = {rem_r, quo_r[DW-1]};
  assign trial_ge = (trial >= {1'b0, hl_eff});

  // rounding step
  logic [DW-KW-1:0] q_int;
  logic [5:0] sh;
  logic [34:0] rnd_sum;
  assign q_int = quo_r[DW-1:KW];
  assign sh = 6'd16 + 6'(q_int[4:0]);
  assign rnd_sum = {1'b0, prod_r} + (35'd1 << (sh - 6'd1));

  // saturating alert sum
  logic [17:0] sum;
  logic [16:0] sum_sat;
  assign sum = {1'b0, dec_r} + {1'b0, increment_r};
  assign sum_sat = (sum > {1'b0, dsst_pkg::SCORE_ONE}) ? dsst_pkg::SCORE_ONE : sum[16:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsst_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_action == dsst_pkg::ACT_ALERT || in_action == dsst_pkg::ACT_QUERY)
            state_nxt = dsst_pkg::ST_READ;
          else
            state_nxt = dsst_pkg::ST_DONE;
        end
      end
      dsst_pkg::ST_READ: state_nxt = dsst_pkg::ST_CHECK;
      dsst_pkg::ST_CHECK: begin
        if (!valid_r[idx_r]) begin
          state_nxt = dsst_pkg::ST_RESULT;
        end else if (rd_sym == sym_r) begin
          if (rd_score == 17'd0 || now_r <= rd_stamp) state_nxt = dsst_pkg::ST_RESULT;
          else state_nxt = dsst_pkg::ST_DIVIDE;
        end else if (cnt_r == (AW + 1)'(TABLE_DEPTH - 1)) begin
          state_nxt = dsst_pkg::ST_RESULT;
        end else begin
          state_nxt = dsst_pkg::ST_READ;
        end
      end
      dsst_pkg::ST_DIVIDE:
        if (dcnt_r == DCW'(1)) state_nxt = dsst_pkg::ST_MULTIPLY;
      dsst_pkg::ST_MULTIPLY: state_nxt = dsst_pkg::ST_ROUND;
      dsst_pkg::ST_ROUND: state_nxt = dsst_pkg::ST_RESULT;
      dsst_pkg::ST_RESULT: state_nxt = dsst_pkg::ST_DONE;
      dsst_pkg::ST_DONE:
        if (!out_valid_r || !out_stall) state_nxt = dsst_pkg::ST_IDLE;
      default: state_nxt = dsst_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_nxt = act_r;
    sym_nxt = sym_r;
    now_nxt = now_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    claimed_nxt = claimed_r;
    score_nxt = score_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dcnt_nxt = dcnt_r;
    prod_nxt = prod_r;
    dec_nxt = dec_r;
    res_nxt = res_r;
    valid_nxt = valid_r;
    out_valid_nxt = out_valid_r;
    out_score_nxt = out_score_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {sym_r, 17'd0, 64'd0};

    // drop the result once the consumer takes it
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      dsst_pkg::ST_IDLE: begin
        if (in_xfer) begin
          act_nxt = dsst_pkg::action_t'(in_action);
          sym_nxt = in_symbol_id;
          now_nxt = in_now_time;
          idx_nxt = AW'(in_symbol_id);
          cnt_nxt = '0;
          claimed_nxt = 1'b0;
          res_nxt = 17'd0;
          if (in_action == dsst_pkg::ACT_CLEAR) valid_nxt = '0;
        end
      end
      dsst_pkg::ST_READ: ram_re = 1'b1;
      dsst_pkg::ST_CHECK: begin
        // claim an empty slot, or the home slot when the probe wraps
        if (!valid_r[idx_r] || (rd_sym != sym_r && cnt_r == (AW + 1)'(TABLE_DEPTH - 1))) begin
          if (valid_r[idx_r]) idx_nxt = AW'(sym_r);
          claimed_nxt = 1'b1;
          dec_nxt = 17'd0;
        end else if (rd_sym == sym_r) begin
          score_nxt = rd_score;
          dec_nxt = rd_score;
          rem_nxt = '0;
          quo_nxt = {now_r - rd_stamp, KW'(0)};
          dcnt_nxt = DCW'(DW);
        end else begin
          idx_nxt = idx_r + AW'(1);
          cnt_nxt = cnt_r + (AW + 1)'(1);
        end
      end
      dsst_pkg::ST_DIVIDE: begin
        // one quotient bit per cycle
        rem_nxt = trial_ge ? 48'(trial - {1'b0, hl_eff}) : trial[47:0];
        quo_nxt = {quo_r[DW-2:0], trial_ge};
        dcnt_nxt = dcnt_r - DCW'(1);
      end
      dsst_pkg::ST_MULTIPLY: prod_nxt = 34'(score_r) * 34'(fac_tab[quo_r[KW-1:0]]);
      dsst_pkg::ST_ROUND: begin
        if (q_int >= (DW - KW)'(17)) dec_nxt = 17'd0;
        else dec_nxt = 17'(rnd_sum >> sh);
      end
      dsst_pkg::ST_RESULT: begin
        // write back the slot on an alert or a newly claimed slot, and form the answer
        valid_nxt[idx_r] = 1'b1;
        if (act_r == dsst_pkg::ACT_ALERT) begin
          ram_we = 1'b1;
          ram_wdata = {sym_r, sum_sat, now_r};
          res_nxt = sum_sat;
        end else begin
          ram_we = claimed_r;
          res_nxt = dec_r;
        end
      end
      dsst_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_score_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsst_pkg::ST_IDLE;
      valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    sym_r <= sym_nxt;
    now_r <= now_nxt;
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    claimed_r <= claimed_nxt;
    score_r <= score_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    prod_r <= prod_nxt;
    dec_r <= dec_nxt;
    res_r <= res_nxt;
    out_score_r <= out_score_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_score_value = out_score_r;

endmodule

### design/dsst_ram.sv
`timescale 1ns / 1ps
module dsst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### tb/sv/decaying_symbol_score_table_top_tb.sv
`timescale 1ns / 1ps
module decaying_symbol_score_table_top_tb;

  localparam int unsigned DEPTH = dsst_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned NFRAC = dsst_pkg::DECAY_ENTRIES_DEF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [47:0] HALF_LIFE_MAX = 48'hFFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [15:0] in_symbol_id;
  logic [63:0] in_now_time;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] out_score_value;
  logic        cfg_we;
  dsst_pkg::cfg_index_t cfg_index;
  logic [47:0] cfg_wdata;

  decaying_symbol_score_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_symbol_id(in_symbol_id), .in_now_time(in_now_time),
    .out_valid(out_valid), .out_stall(out_stall), .out_score_value(out_score_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the score table and registers
  logic        tbl_valid [DEPTH];
  logic [15:0] tbl_symbol [DEPTH];
  logic [16:0] tbl_score [DEPTH];
  logic [63:0] tbl_stamp [DEPTH];
  logic [47:0] cur_half_life;
  logic [16:0] cur_increment;
  logic [63:0] frac_q16 [NFRAC];

  logic [16:0] pending_scores [$];
  int unsigned mismatch_count;
  int unsigned send_pct;
  int unsigned recv_pct;
  int unsigned hold_cnt;
  logic [63:0] clock_ns;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // 2^(-k/NFRAC) in Q16 via a truncated exp(-t) series
  function automatic void build_frac_table();
    logic [63:0] t, term, pos, neg;
    for (int k = 0; k < NFRAC; k++) begin
      t = (64'(k) * dsst_pkg::LN2_Q32) / 64'(NFRAC);
      term = 64'd1 << 32;
      pos = term;
      neg = 64'd0;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * t) >> 32) / 64'(n);
        if (n % 2 == 1) neg += term;
        else pos += term;
      end
      frac_q16[k] = ((pos - neg) + 64'd32768) >> 16;
    end
  endfunction

  function automatic logic [16:0] decayed(logic [16:0] s, logic [63:0] stamp, logic [63:0] t);
    logic [63:0] hl, el, q, r, k, sh, prod;
    hl = (cur_half_life == 48'd0) ? 64'd1 : 64'(cur_half_life);
    if (s == 17'd0 || t <= stamp) return s;
    el = t - stamp;
    q = el / hl;
    if (q >= 64'd17) return 17'd0;
    r = el % hl;
    k = (r * 64'(NFRAC)) / hl;
    if (k >= 64'(NFRAC)) k = 64'(NFRAC - 1);
    sh = 64'd16 + q;
    prod = 64'(s) * frac_q16[k] + (64'd1 << (sh - 1));
    return 17'(prod >> sh);
  endfunction

  function automatic int unsigned find_slot(logic [15:0] sym);
    int unsigned home, idx, hit;
    home = sym % DEPTH;
    idx = home;
    hit = home;
    for (int i = 0; i < DEPTH; i++) begin
      if (!tbl_valid[idx]) begin
        hit = idx;
        tbl_valid[idx] = 1'b1;
        tbl_symbol[idx] = sym;
        tbl_score[idx] = 17'd0;
        tbl_stamp[idx] = 64'd0;
        return hit;
      end
      if (tbl_symbol[idx] == sym) return idx;
      idx = (idx + 1) % DEPTH;
    end
    // table full: take over the home slot
    tbl_valid[home] = 1'b1;
    tbl_symbol[home] = sym;
    tbl_score[home] = 17'd0;
    tbl_stamp[home] = 64'd0;
    return home;
  endfunction

  function automatic logic [16:0] predict_score(dsst_pkg::action_t a, logic [15:0] sym,
                                                logic [63:0] t);
    int unsigned idx;
    logic [17:0] sum;
    case (a)
      dsst_pkg::ACT_ALERT: begin
        idx = find_slot(sym);
        sum = 18'(decayed(tbl_score[idx], tbl_stamp[idx], t)) + 18'(cur_increment);
        if (sum > 18'(dsst_pkg::SCORE_ONE)) sum = 18'(dsst_pkg::SCORE_ONE);
        tbl_score[idx] = 17'(sum);
        tbl_stamp[idx] = t;
        return 17'(sum);
      end
      dsst_pkg::ACT_QUERY: begin
        idx = find_slot(sym);
        return decayed(tbl_score[idx], tbl_stamp[idx], t);
      end
      dsst_pkg::ACT_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
        return 17'd0;
      end
      default: return 17'd0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
    $display("mismatch %s: score_value got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // offer one item; returns at the falling edge after its transfer
  task automatic send_item(dsst_pkg::action_t a, logic [15:0] sym, logic [63:0] t);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= a;
    in_symbol_id <= sym;
    in_now_time <= t;
    do @(posedge clk); while (in_stall);
    pending_scores.push_back(predict_score(a, sym, t));
    @(negedge clk);
  endtask

  // stop offering and hold until every expected score is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(dsst_pkg::cfg_index_t idx, logic [47:0] val);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dsst_pkg::CFG_HALF_LIFE) cur_half_life = val;
    else cur_increment = val[16:0];
  endtask

  // receiver: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("unexpected transfer", out_score_value, 17'd0);
      end else begin
        if (out_score_value !== pending_scores[0])
          report_mismatch("value", out_score_value, pending_scores[0]);
        void'(pending_scores.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [63:0] hl;
    hl = 64'd1000;
    write_reg(dsst_pkg::CFG_HALF_LIFE, 48'd1000);
    write_reg(dsst_pkg::CFG_INCREMENT, 48'd32768);
    send_item(dsst_pkg::ACT_ALERT, 16'd0, 64'd0);
    send_item(dsst_pkg::ACT_QUERY, 16'd0, 64'd0);            // no time advance
    send_item(dsst_pkg::ACT_QUERY, 16'd0, hl);               // one half-life
    send_item(dsst_pkg::ACT_QUERY, 16'd0, hl + 64'd500);     // fractional part
    send_item(dsst_pkg::ACT_ALERT, 16'd0, 64'd10);           // short elapsed time
    send_item(dsst_pkg::ACT_ALERT, 16'd256, 64'd20);         // same home slot, probe
    send_item(dsst_pkg::ACT_QUERY, 16'd512, 64'd30);         // query claims an empty slot
    send_item(dsst_pkg::ACT_QUERY, 16'd256, hl * 64'd16 + 64'd20);
    send_item(dsst_pkg::ACT_QUERY, 16'd256, hl * 64'd17 + 64'd20); // decays to zero
    send_item(dsst_pkg::ACT_ALERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(dsst_pkg::ACT_NONE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(dsst_pkg::ACT_ALERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(dsst_pkg::ACT_ALERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF); // saturate at one
    send_item(dsst_pkg::ACT_CLEAR, 16'h0, 64'd0);
    send_item(dsst_pkg::ACT_QUERY, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF); // zero after clear
    write_reg(dsst_pkg::CFG_INCREMENT, 48'h1FFFF);           // oversized increment
    send_item(dsst_pkg::ACT_ALERT, 16'd7, 64'd100);
    write_reg(dsst_pkg::CFG_INCREMENT, 48'd0);
    send_item(dsst_pkg::ACT_ALERT, 16'd8, 64'd100);
    send_item(dsst_pkg::ACT_QUERY, 16'd8, 64'd5000);         // stored zero stays zero
    write_reg(dsst_pkg::CFG_HALF_LIFE, 48'd0);               // treated as one
    send_item(dsst_pkg::ACT_QUERY, 16'd7, 64'd103);
    write_reg(dsst_pkg::CFG_HALF_LIFE, HALF_LIFE_MAX);
    send_item(dsst_pkg::ACT_QUERY, 16'd7, 64'h8000_0000_0000_0000);
    write_reg(dsst_pkg::CFG_HALF_LIFE, 48'd1);
    send_item(dsst_pkg::ACT_QUERY, 16'd7, 64'd104);
    wait_drain();
  endtask

  // fill every slot, then force a takeover of a home slot
  task automatic test_full_table();
    write_reg(dsst_pkg::CFG_HALF_LIFE, 48'd1000);
    write_reg(dsst_pkg::CFG_INCREMENT, 48'd6554);
    send_item(dsst_pkg::ACT_CLEAR, 16'd0, 64'd0);
    for (int i = 0; i < DEPTH; i++)
      send_item(dsst_pkg::ACT_ALERT, 16'(i * 7 + 3), 64'(i) * 64'd10);
    send_item(dsst_pkg::ACT_ALERT, 16'd40000, 64'd5000);
    send_item(dsst_pkg::ACT_QUERY, 16'd40000, 64'd6000);
    send_item(dsst_pkg::ACT_CLEAR, 16'd0, 64'd0);
    wait_drain();
  endtask

  task automatic run_random(int unsigned n, int unsigned spct, int unsigned rpct);
    int unsigned r;
    dsst_pkg::action_t a;
    logic [15:0] sym;
    logic [63:0] t;
    send_pct = spct;
    recv_pct = rpct;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) a = dsst_pkg::ACT_CLEAR;
      else if (r < 5) a = dsst_pkg::ACT_NONE;
      else if (r < 52) a = dsst_pkg::ACT_ALERT;
      else a = dsst_pkg::ACT_QUERY;
      if ($urandom_range(0, 4) != 0)
        sym = 16'(($urandom_range(0, 3) << 8) | $urandom_range(0, 15));
      else sym = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        t = {$urandom, $urandom};
      end else begin
        if (r < 20) clock_ns = clock_ns;
        else if (r < 40) clock_ns += 64'($urandom_range(0, 3));
        else clock_ns += (64'(cur_half_life) * 64'($urandom_range(0, 160))) / 64'd8;
        t = clock_ns;
      end
      send_item(a, sym, t);
    end
    wait_drain();
  endtask

  task automatic test_random_phases();
    write_reg(dsst_pkg::CFG_HALF_LIFE, 48'd1000);
    write_reg(dsst_pkg::CFG_INCREMENT, 48'd20000);
    run_random(380, 30, 72);
    write_reg(dsst_pkg::CFG_HALF_LIFE, HALF_LIFE_MAX);
    write_reg(dsst_pkg::CFG_INCREMENT, 48'h1FFFF);
    run_random(380, 72, 30);
    write_reg(dsst_pkg::CFG_HALF_LIFE, 48'd1);
    write_reg(dsst_pkg::CFG_INCREMENT, 48'd30000);
    run_random(380, 0, 0);
  endtask

  // long receiver hold-off with the sender still offering
  task automatic test_backpressure();
    write_reg(dsst_pkg::CFG_HALF_LIFE, 48'd777);
    write_reg(dsst_pkg::CFG_INCREMENT, 48'd9000);
    hold_cnt = 400;
    run_random(30, 0, 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = dsst_pkg::ACT_NONE;
    in_symbol_id = 16'd0;
    in_now_time = 64'd0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = dsst_pkg::CFG_HALF_LIFE;
    cfg_wdata = 48'd0;
    mismatch_count = 0;
    send_pct = 0;
    recv_pct = 0;
    hold_cnt = 0;
    clock_ns = 64'd0;
    cur_half_life = dsst_pkg::HALF_LIFE_RST;
    cur_increment = dsst_pkg::INCREMENT_RST;
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    build_frac_table();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // reset values first
    send_item(dsst_pkg::ACT_ALERT, 16'd1, 64'd0);
    send_item(dsst_pkg::ACT_QUERY, 16'd1, 64'd1500000000);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random_phases();
    wait_drain();
    repeat (50) @(negedge clk);
    if (mismatch_count == 0 && pending_scores.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
